@@ hw/rtl/mhpq_pkg.sv @@
// shared types and codes for the min-heap priority queue
package mhpq_pkg;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic displaced;
  } tok_ctl_t;

endpackage

@@ hw/rtl/mhpq_cell.sv @@
// one heap level: entry store for the level, read stage and compare/write stage
module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int LEVEL    = 0,
  parameter int PW       = 11,
  parameter int LW       = 4,
  parameter int EW       = 32,
  parameter int KEY_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  tok_ctl_t       in_ctl,
  input  logic [EW-1:0]  in_ent,
  input  logic [PW-1:0]  in_pos,
  input  logic [LW-1:0]  in_lvl,
  input  logic [PW-1:0]  in_cnt,
  output tok_ctl_t       out_ctl,
  output logic [EW-1:0]  out_ent,
  output logic [PW-1:0]  out_pos,
  output logic [LW-1:0]  out_lvl,
  output logic [PW-1:0]  out_cnt,
  input  logic           wb_in_valid,
  input  logic [PW-1:0]  wb_in_pos,
  input  logic [EW-1:0]  wb_in_ent,
  output logic           wb_out_valid,
  output logic [PW-1:0]  wb_out_pos,
  output logic [EW-1:0]  wb_out_ent,
  input  logic           fetch_valid,
  input  logic [PW-1:0]  fetch_pos,
  output logic [EW-1:0]  rd_ent,
  output logic           fetch_hit,
  output logic           fin
);

  localparam int RW    = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int DEPTH = (LEVEL > 1) ? (1 << (LEVEL - 1)) : 1;

  logic [EW-1:0] mem_l [DEPTH];
  logic [EW-1:0] mem_r [DEPTH];
  logic [EW-1:0] rd_l;
  logic [EW-1:0] rd_r;

  logic [PW-1:0] ins_pos;
  logic [PW-1:0] acc_pos;
  logic [PW-1:0] rd_pos;
  logic [RW-1:0] rd_row;
  logic          rd_side;
  logic          hit_next;

  tok_ctl_t      q_ctl;
  logic          q_hit;
  logic          q_side;
  logic [EW-1:0] q_ent;
  logic [PW-1:0] q_pos;
  logic [PW-1:0] q_apos;
  logic [LW-1:0] q_lvl;
  logic [PW-1:0] q_cnt;

  logic [EW-1:0] stored;
  logic [KEY_BITS-1:0] cur_key;
  logic [KEY_BITS-1:0] st_key;
  logic [KEY_BITS-1:0] l_key;
  logic [KEY_BITS-1:0] r_key;
  logic [KEY_BITS-1:0] best_key;
  logic          sel_l;
  logic          sel_r;
  logic          r_ok;
  logic [PW-1:0] c_right;
  logic [PW-1:0] child;

  logic          own_we;
  logic [PW-1:0] own_pos;
  logic          pass;
  logic [EW-1:0] pass_ent;
  logic [PW-1:0] pass_pos;
  logic          pass_disp;

  logic          we;
  logic [PW-1:0] wr_pos;
  logic [EW-1:0] wr_ent;
  logic [RW-1:0] wr_row;
  logic          wr_side;

  // path position at this level, or first child for a sift-down
  assign ins_pos  = in_pos >> (in_lvl - LW'(LEVEL));
  assign acc_pos  = (in_ctl.op == OP_INSERT) ? ins_pos : {in_pos[PW-2:0], 1'b0};
  assign rd_pos   = in_ctl.valid ? acc_pos : fetch_pos;
  assign hit_next = fetch_valid && ((fetch_pos >> LEVEL) == PW'(1));
  assign rd_side  = (LEVEL == 0) ? 1'b1 : rd_pos[0];

  if (LEVEL > 1) begin : g_row
    assign rd_row = rd_pos[LEVEL-1:1];
    assign wr_row = wr_pos[LEVEL-1:1];
  end else begin : g_row_one
    assign rd_row = '0;
    assign wr_row = '0;
  end

  assign we      = own_we || wb_in_valid;
  assign wr_pos  = wb_in_valid ? wb_in_pos : own_pos;
  assign wr_ent  = wb_in_valid ? wb_in_ent : q_ent;
  assign wr_side = (LEVEL == 0) ? 1'b1 : wr_pos[0];

  always_ff @(posedge clk) begin
    if (we && !wr_side) begin
      mem_l[wr_row] <= wr_ent;
    end
    if (we && wr_side) begin
      mem_r[wr_row] <= wr_ent;
    end
    rd_l <= mem_l[rd_row];
    rd_r <= mem_r[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctl <= '0;
      q_hit <= 1'b0;
    end else begin
      q_ctl <= in_ctl;
      q_hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    q_side <= rd_side;
    q_ent  <= in_ent;
    q_pos  <= in_pos;
    q_apos <= acc_pos;
    q_lvl  <= in_lvl;
    q_cnt  <= in_cnt;
  end

  assign stored    = q_side ? rd_r : rd_l;
  assign rd_ent    = stored;
  assign fetch_hit = q_hit;

  assign cur_key  = q_ent[EW-1 -: KEY_BITS];
  assign st_key   = stored[EW-1 -: KEY_BITS];
  assign l_key    = rd_l[EW-1 -: KEY_BITS];
  assign r_key    = rd_r[EW-1 -: KEY_BITS];

  // smallest of current, left, right; current wins ties, then left
  assign c_right  = q_apos | PW'(1);
  assign r_ok     = c_right <= q_cnt;
  assign sel_l    = l_key < cur_key;
  assign best_key = sel_l ? l_key : cur_key;
  assign sel_r    = r_ok && (r_key < best_key);
  assign child    = sel_r ? c_right : q_apos;

  always_comb begin
    own_we       = 1'b0;
    own_pos      = q_apos;
    pass         = 1'b0;
    pass_ent     = q_ent;
    pass_pos     = q_pos;
    pass_disp    = q_ctl.displaced;
    wb_out_valid = 1'b0;
    wb_out_pos   = q_pos;
    wb_out_ent   = q_ent;
    fin          = 1'b0;
    if (q_ctl.valid) begin
      if (q_ctl.op == OP_INSERT) begin
        if (q_lvl == LW'(LEVEL)) begin
          own_we = 1'b1;
          fin    = 1'b1;
        end else begin
          // once displaced, every lower entry on the path moves down one
          if (q_ctl.displaced || (st_key > cur_key)) begin
            own_we    = 1'b1;
            pass_ent  = stored;
            pass_disp = 1'b1;
          end
          pass = 1'b1;
        end
      end else begin
        wb_out_valid = 1'b1;
        if (sel_r) begin
          wb_out_ent = rd_r;
        end else if (sel_l) begin
          wb_out_ent = rd_l;
        end
        if (sel_l || sel_r) begin
          own_pos = child;
          if (child <= (q_cnt >> 1)) begin
            pass     = 1'b1;
            pass_pos = child;
          end else begin
            own_we = 1'b1;
            fin    = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid     <= pass;
      out_ctl.op        <= q_ctl.op;
      out_ctl.displaced <= pass_disp;
    end
  end

  always_ff @(posedge clk) begin
    if (pass) begin
      out_ent <= pass_ent;
      out_pos <= pass_pos;
      out_lvl <= q_lvl;
      out_cnt <= q_cnt;
    end
  end

endmodule

@@ hw/rtl/min_heap_priority_queue_top.sv @@
// binary min-heap priority queue built as a chain of level cells
//
// Each item is an insert (priority key and payload tag) or an extract of the
// least key. The heap is held one level per cell; an operation walks the chain
// from the root down, each cell doing a registered read of its level store
// and then the compare and write-back. An insert ends at the heap level of
// the new last position. An extract's sift-down ends either by moving the
// entry down into a level or by leaving it at a level with no child smaller;
// when the extract leaves one entry or none, no sift-down runs. The result
// leaves through a holding register and an output register, so a new item
// can be taken while the previous result waits in the output register. An
// insert on a full heap reports full, an extract on an empty heap reports
// empty; both leave the heap untouched.
module min_heap_priority_queue_top
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic [KEY_BITS-1:0]                   priority_req,
  input  logic [TAG_BITS-1:0]                   payload,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [TAG_BITS-1:0]                   out_payload,
  output logic [KEY_BITS-1:0]                   out_priority,
  output logic [1:0]                            status,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int NL = PW;
  localparam int LW = (PW > 1) ? $clog2(PW) : 1;
  localparam int EW = KEY_BITS + TAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_START = 4'b0100,
    S_RUN   = 4'b1000
  } state_t;

  function automatic logic [LW-1:0] lvl_of(input logic [PW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < PW; i++) begin
      if (v[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  state_t        state;
  state_t        state_next;
  logic [PW-1:0] cnt;
  logic [PW-1:0] cnt_next;

  logic          tk_valid;
  logic          tk_to1;
  op_t           tk_op;
  logic [EW-1:0] tk_ent;
  logic [PW-1:0] tk_pos;
  logic [LW-1:0] tk_lvl;
  logic [PW-1:0] tk_cnt;
  logic          tk_set;
  logic          tk_to1_next;
  op_t           tk_op_next;
  logic [EW-1:0] tk_ent_next;
  logic [PW-1:0] tk_pos_next;
  logic [LW-1:0] tk_lvl_next;

  logic          fe_valid;
  logic [PW-1:0] fe_pos;
  logic          fe_set;

  logic                res_pending;
  logic                res_set;
  logic                res_take;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [1:0]          res_status;
  logic [PW-1:0]       res_cnt;
  logic [KEY_BITS-1:0] res_key_next;
  logic [TAG_BITS-1:0] res_tag_next;
  logic [1:0]          res_status_next;

  logic          accept;
  logic [EW-1:0] root_ent;
  logic [EW-1:0] last_ent;
  logic          top_wb;

  tok_ctl_t      ci_ctl [NL];
  logic [EW-1:0] ci_ent [NL];
  logic [PW-1:0] ci_pos [NL];
  logic [LW-1:0] ci_lvl [NL];
  logic [PW-1:0] ci_cnt [NL];
  tok_ctl_t      co_ctl [NL];
  logic [EW-1:0] co_ent [NL];
  logic [PW-1:0] co_pos [NL];
  logic [LW-1:0] co_lvl [NL];
  logic [PW-1:0] co_cnt [NL];
  logic          wbi_valid [NL];
  logic [PW-1:0] wbi_pos [NL];
  logic [EW-1:0] wbi_ent [NL];
  logic          wbo_valid [NL];
  logic [PW-1:0] wbo_pos [NL];
  logic [EW-1:0] wbo_ent [NL];
  logic [EW-1:0] rd_ent [NL];
  logic [NL-1:0] hit;
  logic [NL-1:0] fin;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !((state == S_IDLE) && !res_pending);
  assign res_take = res_pending && (!out_valid || !out_stall);
  assign root_ent = rd_ent[0];
  assign top_wb   = (state == S_START) && (cnt == PW'(1));

  always_comb begin
    last_ent = '0;
    for (int i = 0; i < NL; i++) begin
      if (hit[i]) begin
        last_ent = last_ent | rd_ent[i];
      end
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    tk_set          = 1'b0;
    tk_to1_next     = 1'b0;
    tk_op_next      = OP_INSERT;
    tk_ent_next     = {priority_req, payload};
    tk_pos_next     = cnt + PW'(1);
    tk_lvl_next     = lvl_of(cnt + PW'(1));
    fe_set          = 1'b0;
    res_set         = 1'b0;
    res_key_next    = '0;
    res_tag_next    = '0;
    res_status_next = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_set = 1'b1;
          if (op_t'(opcode) == OP_INSERT) begin
            if (cnt == PW'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              cnt_next   = cnt + PW'(1);
              tk_set     = 1'b1;
              state_next = S_RUN;
            end
          end else begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              res_set    = 1'b0;
              cnt_next   = cnt - PW'(1);
              fe_set     = 1'b1;
              state_next = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = S_START;
      end
      S_START: begin
        res_set      = 1'b1;
        res_key_next = root_ent[EW-1 -: KEY_BITS];
        res_tag_next = root_ent[TAG_BITS-1:0];
        tk_to1_next  = 1'b1;
        tk_op_next   = OP_EXTRACT;
        tk_ent_next  = last_ent;
        tk_pos_next  = PW'(1);
        if (cnt > PW'(1)) begin
          tk_set     = 1'b1;
          state_next = S_RUN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (|fin) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      tk_valid    <= 1'b0;
      fe_valid    <= 1'b0;
      res_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      tk_valid    <= tk_set;
      fe_valid    <= fe_set;
      res_pending <= (res_pending && !res_take) || res_set;
      if (!out_valid || !out_stall) begin
        out_valid <= res_pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tk_set) begin
      tk_to1 <= tk_to1_next;
      tk_op  <= tk_op_next;
      tk_ent <= tk_ent_next;
      tk_pos <= tk_pos_next;
      tk_lvl <= tk_lvl_next;
      tk_cnt <= cnt_next;
    end
    if (fe_set) begin
      fe_pos <= cnt;
    end
    if (res_set) begin
      res_key    <= res_key_next;
      res_tag    <= res_tag_next;
      res_status <= res_status_next;
      res_cnt    <= cnt_next;
    end
    if (res_take) begin
      out_payload  <= res_tag;
      out_priority <= res_key;
      status       <= res_status;
      entry_count  <= res_cnt;
    end
  end

  // token into the root cell for inserts, into level one for sift-downs
  always_comb begin
    ci_ctl[0] = '{valid: tk_valid && !tk_to1, op: tk_op, displaced: 1'b0};
    ci_ent[0] = tk_ent;
    ci_pos[0] = tk_pos;
    ci_lvl[0] = tk_lvl;
    ci_cnt[0] = tk_cnt;
    for (int i = 1; i < NL; i++) begin
      ci_ctl[i] = co_ctl[i-1];
      ci_ent[i] = co_ent[i-1];
      ci_pos[i] = co_pos[i-1];
      ci_lvl[i] = co_lvl[i-1];
      ci_cnt[i] = co_cnt[i-1];
    end
    if (!co_ctl[0].valid) begin
      ci_ctl[1] = '{valid: tk_valid && tk_to1, op: tk_op, displaced: 1'b0};
      ci_ent[1] = tk_ent;
      ci_pos[1] = tk_pos;
      ci_lvl[1] = tk_lvl;
      ci_cnt[1] = tk_cnt;
    end
  end

  always_comb begin
    for (int i = 0; i < NL - 1; i++) begin
      wbi_valid[i] = wbo_valid[i+1];
      wbi_pos[i]   = wbo_pos[i+1];
      wbi_ent[i]   = wbo_ent[i+1];
    end
    wbi_valid[NL-1] = 1'b0;
    wbi_pos[NL-1]   = '0;
    wbi_ent[NL-1]   = '0;
    if (top_wb) begin
      wbi_valid[0] = 1'b1;
      wbi_pos[0]   = PW'(1);
      wbi_ent[0]   = last_ent;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_cell
    mhpq_cell #(
      .LEVEL    (g),
      .PW       (PW),
      .LW       (LW),
      .EW       (EW),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .in_ctl       (ci_ctl[g]),
      .in_ent       (ci_ent[g]),
      .in_pos       (ci_pos[g]),
      .in_lvl       (ci_lvl[g]),
      .in_cnt       (ci_cnt[g]),
      .out_ctl      (co_ctl[g]),
      .out_ent      (co_ent[g]),
      .out_pos      (co_pos[g]),
      .out_lvl      (co_lvl[g]),
      .out_cnt      (co_cnt[g]),
      .wb_in_valid  (wbi_valid[g]),
      .wb_in_pos    (wbi_pos[g]),
      .wb_in_ent    (wbi_ent[g]),
      .wb_out_valid (wbo_valid[g]),
      .wb_out_pos   (wbo_pos[g]),
      .wb_out_ent   (wbo_ent[g]),
      .fetch_valid  (fe_valid),
      .fetch_pos    (fe_pos),
      .rd_ent       (rd_ent[g]),
      .fetch_hit    (hit[g]),
      .fin          (fin[g])
    );
  end

`ifndef SYNTHESIS
  a_fin_only_running: assert property (@(posedge clk) disable iff (rst)
    (|fin) |-> (state == S_RUN))
    else $error("level cell finished outside a running operation");

  a_single_fin: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fin))
    else $error("more than one level cell finished at once");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= PW'(CAPACITY))
    else $error("entry count above capacity");

  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    !co_ctl[NL-1].valid && !wbo_valid[0])
    else $error("token left the chain of level cells");
`endif

endmodule
